[rtl/core/csrmv_pkg.sv]
// Package for the CSR sparse matrix-vector row engine.
// Request/result payload structs, mode codes and fixed-point constants.
// No dependencies.
package csrmv_pkg;

	localparam int IDX_W     = 10;
	localparam int DATA_W    = 32;
	localparam int ROW_W     = 16;
	localparam int ACC_W     = 64;
	localparam int FRAC_BITS = 16;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_NZ    = 2'd1;
	localparam logic [1:0] MODE_EMPTY = 2'd2;

	// Half an LSB of Q.16, for round to nearest
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

	typedef struct packed {
		logic [1:0]              mode;
		logic [IDX_W-1:0]        index;
		logic signed [DATA_W-1:0] value;
		logic                    last_in_row;
	} csrmv_req_t;

	typedef struct packed {
		logic [ROW_W-1:0]        row_number;
		logic signed [DATA_W-1:0] row_sum;
		logic                    saturated;
	} csrmv_rsp_t;

endpackage

[rtl/core/csrmv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the dense vector store. No dependencies.
module csrmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/csr_sparse_matvec_rows.sv]
// Top level of the CSR sparse matrix-vector row engine.
// Depends on csrmv_pkg (payload types, mode codes) and csrmv_ram (vector store).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  req     | in        | req_valid / req_stall   | mode, index, value, last_in_row
//  rsp     | out       | rsp_valid / rsp_stall   | row_number, row_sum, saturated
//
// Flow: one request per cycle while req_stall is low. The request closing a row
//   passes the request register (vector store read at that edge), then multiply,
//   round, accumulate into the result register. The accumulator is the only loop.
// Reset: control state and the accumulator clear at once. The vector store has
//   no clearing pass; its entries are undefined until loaded.
// Stalls: each stage moves when the one after it is empty or moving, so
//   bubbles are squeezed out; req_stall rises only once the pipe is full.

module csr_sparse_matvec_rows #(
	parameter int VEC_DEPTH   = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  csrmv_pkg::csrmv_req_t  req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output csrmv_pkg::csrmv_rsp_t  rsp
);
	import csrmv_pkg::*;

	localparam int AW     = $clog2(VEC_DEPTH);
	localparam int PROD_W = 2 * VALUE_WIDTH;
	localparam int HEAD_W = ACC_W - VALUE_WIDTH + 1;  // bits that must agree to fit

	localparam logic signed [VALUE_WIDTH-1:0] SUM_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] SUM_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]       ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]       ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// ---------------------------------------------------------------------
	// Acceptance and vector store access
	// ---------------------------------------------------------------------
	logic accept;
	logic idx_ok;
	logic ram_we;
	logic ram_re;
	logic [AW-1:0] ram_addr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	logic ready_s1;
	logic ready_s2;
	logic ready_s3;

	assign accept    = req_valid && !req_stall;
	assign req_stall = !ready_s1;
	// Indices past the store: loads dropped, nonzeros see a zero element
	assign idx_ok    = (32'(req.index) < 32'(VEC_DEPTH));
	assign ram_addr  = AW'(req.index);
	assign ram_we    = accept && (req.mode == MODE_LOAD) && idx_ok;
	assign ram_re    = accept && (req.mode == MODE_NZ) && idx_ok;

	csrmv_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(VEC_DEPTH)
	) u_vec_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(req.value[VALUE_WIDTH-1:0]),
		.re   (ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------------
	// Stage 1: request register; RAM data lines up with it.
	// Loads and unused mode codes end here.
	// ---------------------------------------------------------------------
	logic                          v_s1;
	logic                          nz_s1;
	logic                          close_s1;
	logic                          ok_s1;
	logic signed [VALUE_WIDTH-1:0] val_s1;
	logic signed [VALUE_WIDTH-1:0] elem_s1;

	assign ready_s1 = !v_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= accept && ((req.mode == MODE_NZ) || (req.mode == MODE_EMPTY));
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ready_s1) begin
			nz_s1    <= (req.mode == MODE_NZ);
			close_s1 <= (req.mode == MODE_EMPTY) || req.last_in_row;
			ok_s1    <= idx_ok;
			val_s1   <= req.value[VALUE_WIDTH-1:0];
		end
	end

	assign elem_s1 = ok_s1 ? $signed(ram_rdata) : '0;

	// ---------------------------------------------------------------------
	// Stage 2: exact product, Q32.32
	// ---------------------------------------------------------------------
	logic                     v_s2;
	logic                     nz_s2;
	logic                     close_s2;
	logic signed [PROD_W-1:0] prod_s2;

	assign ready_s2 = !v_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			nz_s2    <= nz_s1;
			close_s2 <= close_s1;
			prod_s2  <= val_s1 * elem_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: round to Q.16, nearest with ties toward +inf
	// ---------------------------------------------------------------------
	logic                    v_s3;
	logic                    nz_s3;
	logic                    close_s3;
	logic signed [ACC_W-1:0] term_s3;
	logic signed [ACC_W-1:0] rounded;

	assign rounded = (ACC_W'(prod_s2) + ROUND_HALF) >>> FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && ready_s3) begin
			nz_s3    <= nz_s2;
			close_s3 <= close_s2;
			term_s3  <= rounded;
		end
	end

	// ---------------------------------------------------------------------
	// Accumulate and close the row into the result register
	// ---------------------------------------------------------------------
	logic signed [ACC_W-1:0]       acc_q;
	logic                          clip_q;
	logic [ROW_W-1:0]              row_q;
	logic                          rsp_valid_q;
	csrmv_rsp_t                    rsp_q;

	logic                          rsp_free;
	logic                          adv_s3;
	logic                          fire;
	logic signed [ACC_W:0]         sum_wide;
	logic signed [ACC_W-1:0]       acc_new;
	logic                          clip_new;
	logic [HEAD_W-1:0]             head;
	logic                          fits;
	logic signed [VALUE_WIDTH-1:0] sum_narrow;

	assign rsp_free = !rsp_valid_q || !rsp_stall;
	// Non-closing nonzeros only touch the accumulator; closes need the result slot
	assign adv_s3   = v_s3 && (!close_s3 || rsp_free);
	assign ready_s3 = !v_s3 || adv_s3;
	assign fire     = adv_s3 && close_s3;

	assign sum_wide = {acc_q[ACC_W-1], acc_q} + {term_s3[ACC_W-1], term_s3};

	always_comb begin
		acc_new  = acc_q;
		clip_new = clip_q;
		if (nz_s3) begin
			if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
				acc_new  = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
				clip_new = 1'b1;
			end else begin
				acc_new = sum_wide[ACC_W-1:0];
			end
		end
	end

	// Row sum fits the value range when all bits from the value sign up agree
	assign head = acc_new[ACC_W-1:VALUE_WIDTH-1];
	assign fits = (&head) || !(|head);
	assign sum_narrow = fits ? acc_new[VALUE_WIDTH-1:0]
	                         : (acc_new[ACC_W-1] ? SUM_MIN : SUM_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			clip_q      <= 1'b0;
			row_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv_s3) begin
				if (close_s3) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
					row_q  <= row_q + 1'b1;
				end else begin
					acc_q  <= acc_new;
					clip_q <= clip_new;
				end
			end
			if (rsp_free) begin
				rsp_valid_q <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.row_number <= row_q;
			rsp_q.row_sum    <= DATA_W'(sum_narrow);
			rsp_q.saturated  <= clip_new || !fits;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
